### sv/pidh_pkg.sv
// Shared types, widths and constants for the heater PID controller.
`timescale 1ns / 1ps
`default_nettype none

package pidh_pkg;

  localparam int GAIN_FRAC_BITS = 16;

  localparam int TEMP_W   = 16;
  localparam int DT_W     = 16;
  localparam int SETP_W   = 13;
  localparam int BAND_W   = 10;
  localparam int FAN_W    = 8;
  localparam int GAIN_W   = 24;
  localparam int HMAX_W   = 8;
  localparam int LEVEL_W  = 8;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam int ERR_W    = 18;
  localparam int CHG_W    = ERR_W + 1;
  localparam int SUM_W    = 32;
  localparam int MUL_B_W  = 32;
  localparam int PROD_W   = GAIN_W + 1 + MUL_B_W;
  localparam int DNUM_W   = GAIN_W + CHG_W - 1;
  localparam int QUO_W    = DNUM_W + 1;
  localparam int ACC_W    = PROD_W + 1;
  localparam int CNT_W    = $clog2(DNUM_W + 1);

  localparam int OPEN_LIMIT    = -3000;
  localparam int SHORT_LIMIT   = 12000;
  localparam int HEAT_ON_BELOW = 7700;
  localparam int HEAT_OFF_AT   = 8000;
  localparam int SUM_CEILING   = 20000;
  localparam int FAN_MIN       = 35;
  localparam int FAN_TOP       = 250;

  localparam int SETPOINT_RST   = 3400;
  localparam int BAND_RST       = 20;
  localparam int FAN_LEVEL_RST  = 35;
  localparam int GAIN_P_RST     = 45875;
  localparam int GAIN_I_RST     = 328;
  localparam int GAIN_D_RST     = 65536;
  localparam int HEATER_MAX_RST = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT,
    CFG_BAND,
    CFG_FAN_LEVEL,
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_HEATER_MAX
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FAULT_NONE,
    FAULT_AIR1_OPEN,
    FAULT_AIR1_SHORT,
    FAULT_AIR2_OPEN,
    FAULT_AIR2_SHORT,
    FAULT_HEAT_OPEN,
    FAULT_HEAT_SHORT
  } fault_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL_D,
    S_MUL_P,
    S_MUL_I,
    S_ACC_I,
    S_WAIT,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

### sv/pidh_mul.sv
// Registered signed multiplier shared by the three PID terms.
`timescale 1ns / 1ps
`default_nettype none

module pidh_mul
  import pidh_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic [GAIN_W-1:0]          a_i,
  input  wire logic signed [MUL_B_W-1:0]  b_i,
  output logic signed [PROD_W-1:0]        p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= $signed({1'b0, a_i}) * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### sv/pidh_div.sv
// Serial restoring divider with floor rounding for the derivative term.
`timescale 1ns / 1ps
`default_nettype none

module pidh_div
  import pidh_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [DNUM_W-1:0]         num_i,
  input  wire logic                      neg_i,
  input  wire logic [DT_W-1:0]           den_i,
  output logic                           done_o,
  output logic signed [QUO_W-1:0]        quo_o
);

  logic                    busy_q, fix_q, done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [DNUM_W-1:0]       num_q;
  logic [DT_W-1:0]         rem_q, den_q;
  logic                    neg_q;
  logic signed [QUO_W-1:0] quo_q;

  logic [DT_W:0]           rem_sh;
  logic                    ge;
  logic [DT_W-1:0]         rem_n;
  logic [QUO_W-1:0]        q_ext;

  always_comb begin
    rem_sh = {rem_q, num_q[DNUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_n  = ge ? DT_W'(rem_sh - {1'b0, den_q}) : rem_sh[DT_W-1:0];
    q_ext  = {1'b0, num_q} + QUO_W'(neg_q && (rem_q != '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DNUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        fix_q  <= 1'b1;
      end
    end else if (fix_q) begin
      fix_q  <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      num_q <= {num_q[DNUM_W-2:0], ge};
      rem_q <= rem_n;
    end else if (fix_q) begin
      quo_q <= neg_q ? $signed(-q_ext) : $signed(q_ext);
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### sv/pid_heater_step_with_sensor_faults.sv
// Top level: sensor fault checks, PID sequencer, heater guard and outputs.
// Without a fault, the result waits on the 42-step serial divider for the derivative term;
// on a fault the sequencer goes straight from evaluation to the result.
// Throughput: a new request is taken once the previous one has reached the output
// register, which may still stall.
// Reset clears the PID state and heater level and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module pid_heater_step_with_sensor_faults
  import pidh_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,

  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [CFG_W-1:0]          cfg_wdata_i,

  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [TEMP_W-1:0]  air1_temp_i,
  input  wire logic signed [TEMP_W-1:0]  air2_temp_i,
  input  wire logic signed [TEMP_W-1:0]  heater_temp_i,
  input  wire logic [DT_W-1:0]           elapsed_ms_i,

  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [LEVEL_W-1:0]             heater_duty_o,
  output logic [FAN_W-1:0]               fan_duty_o,
  output logic                           run_led_o,
  output logic                           alarm_led_o,
  output logic [2:0]                     fault_o,
  output logic signed [TEMP_W-1:0]       air_temp_o
);

  localparam int HI_W = ACC_W - GAIN_FRAC_BITS;

  state_e state_q, state_d;

  logic [SETP_W-1:0]  setpoint_q;
  logic [BAND_W-1:0]  band_q;
  logic [FAN_W-1:0]   fan_level_q;
  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [HMAX_W-1:0]  heater_max_q;

  logic signed [ERR_W-1:0]  prev_err_q;
  logic signed [SUM_W-1:0]  err_sum_q;
  logic [LEVEL_W-1:0]       heater_level_q;

  logic signed [TEMP_W-1:0] a1_q, a2_q, th_q;
  logic [DT_W-1:0]          dt_q;
  logic signed [TEMP_W-1:0] air_q;
  fault_e                   fault_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [CHG_W-1:0]  chg_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic                     out_valid_q;
  logic [LEVEL_W-1:0]       out_heater_q;
  logic [FAN_W-1:0]         out_fan_q;
  logic                     out_run_q, out_alarm_q;
  fault_e                   out_fault_q;
  logic signed [TEMP_W-1:0] out_air_q;

  logic accept, out_free, done_fire, div_start, div_done;
  logic signed [QUO_W-1:0]  div_quo;
  logic signed [PROD_W-1:0] prod;
  logic [GAIN_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  logic signed [TEMP_W:0]   pair_sum;
  logic signed [TEMP_W-1:0] air_c;
  fault_e                   fault_c;
  logic signed [ERR_W-1:0]  err_c;
  logic signed [CHG_W-1:0]  chg_c;
  logic signed [SUM_W:0]    sum_raw;
  logic signed [SUM_W-1:0]  sum_c;

  logic signed [DNUM_W:0]   dprod;
  logic [DNUM_W-1:0]        dmag;
  logic [DT_W-1:0]          den;

  logic [HI_W-1:0]          acc_hi;
  logic [LEVEL_W-1:0]       pid_val, level_new;
  logic signed [TEMP_W:0]   air_w, lo_w, hi_w;
  logic                     alarm_c;
  logic [FAN_W-1:0]         fan_c;

  function automatic fault_e sensor_check(logic signed [TEMP_W-1:0] t, fault_e open_code,
                                          fault_e short_code);
    fault_e f;
    f = FAULT_NONE;
    if (t < $signed(TEMP_W'(OPEN_LIMIT))) begin
      f = open_code;
    end else if (t > $signed(TEMP_W'(SHORT_LIMIT))) begin
      f = short_code;
    end
    return f;
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign done_fire  = (state_q == S_DONE) && out_free;

  // Evaluate the latched request
  always_comb begin
    fault_e f1, f2, f3;
    pair_sum = $signed({a1_q[TEMP_W-1], a1_q}) + $signed({a2_q[TEMP_W-1], a2_q});
    air_c    = pair_sum[TEMP_W:1];
    f1 = sensor_check(a1_q, FAULT_AIR1_OPEN, FAULT_AIR1_SHORT);
    f2 = sensor_check(a2_q, FAULT_AIR2_OPEN, FAULT_AIR2_SHORT);
    f3 = sensor_check(th_q, FAULT_HEAT_OPEN, FAULT_HEAT_SHORT);
    if (f1 != FAULT_NONE) begin
      fault_c = f1;
    end else if (f2 != FAULT_NONE) begin
      fault_c = f2;
    end else begin
      fault_c = f3;
    end
    err_c = $signed({{(ERR_W-SETP_W){1'b0}}, setpoint_q})
          - $signed({{(ERR_W-TEMP_W){air_c[TEMP_W-1]}}, air_c});
    chg_c = $signed({err_c[ERR_W-1], err_c}) - $signed({prev_err_q[ERR_W-1], prev_err_q});
    sum_raw = $signed({err_sum_q[SUM_W-1], err_sum_q})
            + $signed({{(SUM_W+1-ERR_W){err_c[ERR_W-1]}}, err_c});
    if (sum_raw > $signed((SUM_W+1)'(SUM_CEILING))) begin
      sum_c = SUM_W'(SUM_CEILING);
    end else if (sum_raw[SUM_W] && !sum_raw[SUM_W-1]) begin
      sum_c = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_c = sum_raw[SUM_W-1:0];
    end
  end

  // Derivative product to divider
  always_comb begin
    dprod = prod[DNUM_W:0];
    dmag  = dprod[DNUM_W] ? DNUM_W'(-dprod) : dprod[DNUM_W-1:0];
    den   = (dt_q == '0) ? DT_W'(1) : dt_q;
  end

  // Clamp, heater guard, alarm and fan
  always_comb begin
    acc_hi = acc_q[ACC_W-1:GAIN_FRAC_BITS];
    if (acc_q[ACC_W-1]) begin
      pid_val = '0;
    end else if (acc_hi > HI_W'(heater_max_q)) begin
      pid_val = LEVEL_W'(heater_max_q);
    end else begin
      pid_val = acc_hi[LEVEL_W-1:0];
    end
    if (th_q < $signed(TEMP_W'(HEAT_ON_BELOW))) begin
      level_new = pid_val;
    end else if (th_q >= $signed(TEMP_W'(HEAT_OFF_AT))) begin
      level_new = '0;
    end else begin
      level_new = heater_level_q;
    end
    air_w   = $signed({air_q[TEMP_W-1], air_q});
    lo_w    = $signed({{(TEMP_W+1-SETP_W){1'b0}}, setpoint_q})
            - $signed({{(TEMP_W+1-BAND_W){1'b0}}, band_q});
    hi_w    = $signed({{(TEMP_W+1-SETP_W){1'b0}}, setpoint_q})
            + $signed({{(TEMP_W+1-BAND_W){1'b0}}, band_q});
    alarm_c = (air_w < lo_w) || (air_w > hi_w);
    if (fan_level_q < FAN_W'(FAN_MIN)) begin
      fan_c = '0;
    end else if (fan_level_q > FAN_W'(FAN_TOP)) begin
      fan_c = FAN_W'(FAN_TOP);
    end else begin
      fan_c = fan_level_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    mul_a     = gain_p_q;
    mul_b     = {{(MUL_B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = (fault_c != FAULT_NONE) ? S_DONE : S_MUL_D;
      end
      S_MUL_D: begin
        mul_a   = gain_d_q;
        mul_b   = {{(MUL_B_W-CHG_W){chg_q[CHG_W-1]}}, chg_q};
        state_d = S_MUL_P;
      end
      S_MUL_P: begin
        div_start = 1'b1;
        state_d   = S_MUL_I;
      end
      S_MUL_I: begin
        mul_a   = gain_i_q;
        mul_b   = sum_q;
        state_d = S_ACC_I;
      end
      S_ACC_I: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= SETP_W'(SETPOINT_RST);
      band_q       <= BAND_W'(BAND_RST);
      fan_level_q  <= FAN_W'(FAN_LEVEL_RST);
      gain_p_q     <= GAIN_W'(GAIN_P_RST);
      gain_i_q     <= GAIN_W'(GAIN_I_RST);
      gain_d_q     <= GAIN_W'(GAIN_D_RST);
      heater_max_q <= HMAX_W'(HEATER_MAX_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SETPOINT:   setpoint_q   <= cfg_wdata_i[SETP_W-1:0];
        CFG_BAND:       band_q       <= cfg_wdata_i[BAND_W-1:0];
        CFG_FAN_LEVEL:  fan_level_q  <= cfg_wdata_i[FAN_W-1:0];
        CFG_GAIN_P:     gain_p_q     <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_I:     gain_i_q     <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_D:     gain_d_q     <= cfg_wdata_i[GAIN_W-1:0];
        CFG_HEATER_MAX: heater_max_q <= cfg_wdata_i[HMAX_W-1:0];
        default: ;
      endcase
    end
  end

  // PID state and heater level commit with the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q     <= '0;
      err_sum_q      <= '0;
      heater_level_q <= '0;
    end else if (done_fire) begin
      if (fault_q == FAULT_NONE) begin
        prev_err_q     <= err_q;
        err_sum_q      <= sum_q;
        heater_level_q <= level_new;
      end else begin
        heater_level_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a1_q <= air1_temp_i;
      a2_q <= air2_temp_i;
      th_q <= heater_temp_i;
      dt_q <= elapsed_ms_i;
    end
    if (state_q == S_EVAL) begin
      air_q   <= air_c;
      fault_q <= fault_c;
      err_q   <= err_c;
      chg_q   <= chg_c;
      sum_q   <= sum_c;
    end
    priority if (state_q == S_MUL_I) begin
      acc_q <= ACC_W'(prod);
    end else if (state_q == S_ACC_I) begin
      acc_q <= acc_q + ACC_W'(prod);
    end else if ((state_q == S_WAIT) && div_done) begin
      acc_q <= acc_q + ACC_W'(div_quo);
    end else begin
      acc_q <= acc_q;
    end
    if (done_fire) begin
      out_air_q   <= air_q;
      out_fault_q <= fault_q;
      if (fault_q == FAULT_NONE) begin
        out_heater_q <= level_new;
        out_fan_q    <= fan_c;
        out_run_q    <= 1'b1;
        out_alarm_q  <= alarm_c;
      end else begin
        out_heater_q <= '0;
        out_fan_q    <= '0;
        out_run_q    <= 1'b0;
        out_alarm_q  <= 1'b0;
      end
    end
  end

  pidh_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  pidh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dmag),
    .neg_i   (dprod[DNUM_W]),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_valid_o   = out_valid_q;
  assign heater_duty_o = out_heater_q;
  assign fan_duty_o    = out_fan_q;
  assign run_led_o     = out_run_q;
  assign alarm_led_o   = out_alarm_q;
  assign fault_o       = out_fault_q;
  assign air_temp_o    = out_air_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request accepted while busy");

  a_fault_outputs_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (fault_o != FAULT_NONE)) |->
      (heater_duty_o == '0) && (fan_duty_o == '0) && !run_led_o && !alarm_led_o)
    else $error("outputs active with a sensor fault");

  a_run_matches_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_led_o == (fault_o == FAULT_NONE)))
    else $error("run led disagrees with fault code");

  a_fan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fan_duty_o <= FAN_W'(FAN_TOP)))
    else $error("fan duty above range");

  a_div_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WAIT) && div_done) |=> (state_q == S_DONE))
    else $error("sequencer missed divider completion");

endmodule

`default_nettype wire

### test/pidh_tick_checker.sv
// Tick checker for the heater PID block: predicts every control tick and compares its result.
`timescale 1ns / 1ps

module pidh_tick_checker
  import pidh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [TEMP_W-1:0] air1_temp_i,
  input  logic signed [TEMP_W-1:0] air2_temp_i,
  input  logic signed [TEMP_W-1:0] heater_temp_i,
  input  logic [DT_W-1:0]          elapsed_ms_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [LEVEL_W-1:0]       heater_duty_i,
  input  logic [FAN_W-1:0]         fan_duty_i,
  input  logic                     run_led_i,
  input  logic                     alarm_led_i,
  input  logic [2:0]               fault_i,
  input  logic signed [TEMP_W-1:0] air_temp_i,
  output int unsigned              fail_count_o,
  output int unsigned              result_count_o
);

  localparam longint SUM_FLOOR = -64'sd2147483648;

  typedef struct {
    logic [LEVEL_W-1:0]       heater_duty;
    logic [FAN_W-1:0]         fan_duty;
    logic                     run_led;
    logic                     alarm_led;
    fault_e                   fault;
    logic signed [TEMP_W-1:0] air_temp;
  } tick_result_t;

  logic [SETP_W-1:0]  setpoint;
  logic [BAND_W-1:0]  band;
  logic [FAN_W-1:0]   fan_level;
  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;
  logic [HMAX_W-1:0]  heater_max;
  int                 prev_error;
  int                 error_sum;
  logic [LEVEL_W-1:0] heater_level;
  tick_result_t       expected_ticks[$];

  function automatic fault_e sensor_code(input logic signed [TEMP_W-1:0] t,
                                         input fault_e open_code, input fault_e short_code);
    if (t < OPEN_LIMIT) return open_code;
    if (t > SHORT_LIMIT) return short_code;
    return FAULT_NONE;
  endfunction

  function automatic tick_result_t control_tick(input logic signed [TEMP_W-1:0] a1, a2, th,
                                                input logic [DT_W-1:0] dt);
    tick_result_t       r;
    logic signed [TEMP_W:0] both;
    longint             air;
    longint             err;
    longint             sum;
    longint             change;
    longint             step_ms;
    longint             deriv_num;
    longint             deriv;
    longint             total;
    longint             one;
    logic [LEVEL_W-1:0] pid;
    int                 fan;
    both = a1 + a2;
    air = both >>> 1;
    r.air_temp = TEMP_W'(both >>> 1);
    r.fault = sensor_code(a1, FAULT_AIR1_OPEN, FAULT_AIR1_SHORT);
    if (r.fault == FAULT_NONE) r.fault = sensor_code(a2, FAULT_AIR2_OPEN, FAULT_AIR2_SHORT);
    if (r.fault == FAULT_NONE) r.fault = sensor_code(th, FAULT_HEAT_OPEN, FAULT_HEAT_SHORT);
    if (r.fault != FAULT_NONE) begin
      heater_level = '0;
      r.fan_duty = '0;
      r.run_led = 1'b0;
      r.alarm_led = 1'b0;
    end else begin
      err = longint'(setpoint) - air;
      sum = longint'(error_sum) + err;
      if (sum > SUM_CEILING) sum = SUM_CEILING;
      if (sum < SUM_FLOOR) sum = SUM_FLOOR;
      error_sum = int'(sum);
      step_ms = (dt == '0) ? 1 : longint'(dt);
      change = err - longint'(prev_error);
      deriv_num = longint'(gain_d) * change;
      if (deriv_num >= 0) deriv = deriv_num / step_ms;
      else deriv = -((-deriv_num + step_ms - 1) / step_ms);
      one = longint'(1) << GAIN_FRAC_BITS;
      total = longint'(gain_p) * err + longint'(gain_i) * sum + deriv;
      if (total < 0) pid = '0;
      else if (total >= (longint'(heater_max) + 1) * one) pid = heater_max;
      else pid = LEVEL_W'(total / one);
      prev_error = int'(err);
      if (th < HEAT_ON_BELOW) heater_level = pid;
      else if (th >= HEAT_OFF_AT) heater_level = '0;
      r.alarm_led = (air < longint'(setpoint) - longint'(band)) ||
                    (air > longint'(setpoint) + longint'(band));
      r.run_led = 1'b1;
      fan = fan_level;
      if (fan < FAN_MIN) fan = 0;
      if (fan > FAN_TOP) fan = FAN_TOP;
      r.fan_duty = FAN_W'(fan);
    end
    r.heater_duty = heater_level;
    return r;
  endfunction

  function automatic int field_bad(input string name, input longint want, input longint got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int unsigned  bad;
    tick_result_t want;
    bad = 0;
    if (!rst_ni) begin
      setpoint = SETP_W'(SETPOINT_RST);
      band = BAND_W'(BAND_RST);
      fan_level = FAN_W'(FAN_LEVEL_RST);
      gain_p = GAIN_W'(GAIN_P_RST);
      gain_i = GAIN_W'(GAIN_I_RST);
      gain_d = GAIN_W'(GAIN_D_RST);
      heater_max = HMAX_W'(HEATER_MAX_RST);
      prev_error = 0;
      error_sum = 0;
      heater_level = '0;
      expected_ticks.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SETPOINT:   setpoint = cfg_wdata_i[SETP_W-1:0];
          CFG_BAND:       band = cfg_wdata_i[BAND_W-1:0];
          CFG_FAN_LEVEL:  fan_level = cfg_wdata_i[FAN_W-1:0];
          CFG_GAIN_P:     gain_p = cfg_wdata_i[GAIN_W-1:0];
          CFG_GAIN_I:     gain_i = cfg_wdata_i[GAIN_W-1:0];
          CFG_GAIN_D:     gain_d = cfg_wdata_i[GAIN_W-1:0];
          CFG_HEATER_MAX: heater_max = cfg_wdata_i[HMAX_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual fault %0d air %0d",
                   $time, fault_i, air_temp_i);
          bad = 1;
        end else begin
          want = expected_ticks.pop_front();
          bad = field_bad("heater_duty", want.heater_duty, heater_duty_i)
              + field_bad("fan_duty", want.fan_duty, fan_duty_i)
              + field_bad("run_led", want.run_led, run_led_i)
              + field_bad("alarm_led", want.alarm_led, alarm_led_i)
              + field_bad("fault", want.fault, fault_i)
              + field_bad("air_temp", want.air_temp, air_temp_i);
        end
        result_count_o <= result_count_o + 1;
      end
      if (in_valid_i && in_ready_i)
        expected_ticks.push_back(control_tick(air1_temp_i, air2_temp_i, heater_temp_i,
                                              elapsed_ms_i));
      if (bad != 0) fail_count_o <= fail_count_o + bad;
    end
  end

endmodule

### test/pid_heater_step_with_sensor_faults_test.sv
// Testbench top for the heater PID block: reset, register settings, tick stimulus and verdict.
`timescale 1ns / 1ps

module pid_heater_step_with_sensor_faults_test;
  import pidh_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTING_RUNS = 9;
  localparam int TICKS_PER_SET = 64;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    logic [SETP_W-1:0] setpoint;
    logic [BAND_W-1:0] band;
    logic [FAN_W-1:0]  fan_level;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [HMAX_W-1:0] heater_max;
  } reg_set_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx = '0;
  logic [CFG_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [TEMP_W-1:0] air1_temp = '0;
  logic signed [TEMP_W-1:0] air2_temp = '0;
  logic signed [TEMP_W-1:0] heater_temp = '0;
  logic [DT_W-1:0]          elapsed_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [LEVEL_W-1:0]       heater_duty;
  logic [FAN_W-1:0]         fan_duty;
  logic                     run_led;
  logic                     alarm_led;
  logic [2:0]               fault;
  logic signed [TEMP_W-1:0] air_temp;
  int unsigned              tick_fails;
  int unsigned              ticks_checked;

  int unsigned sent = 0;
  int unsigned noise_ticks = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;
  int          cur_setpoint = SETPOINT_RST;

  pid_heater_step_with_sensor_faults u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .air1_temp_i   (air1_temp),
    .air2_temp_i   (air2_temp),
    .heater_temp_i (heater_temp),
    .elapsed_ms_i  (elapsed_ms),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .heater_duty_o (heater_duty),
    .fan_duty_o    (fan_duty),
    .run_led_o     (run_led),
    .alarm_led_o   (alarm_led),
    .fault_o       (fault),
    .air_temp_o    (air_temp)
  );

  pidh_tick_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .air1_temp_i    (air1_temp),
    .air2_temp_i    (air2_temp),
    .heater_temp_i  (heater_temp),
    .elapsed_ms_i   (elapsed_ms),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .heater_duty_i  (heater_duty),
    .fan_duty_i     (fan_duty),
    .run_led_i      (run_led),
    .alarm_led_i    (alarm_led),
    .fault_i        (fault),
    .air_temp_i     (air_temp),
    .fail_count_o   (tick_fails),
    .result_count_o (ticks_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int clamp_temp(input int v);
    if (v < OPEN_LIMIT) return OPEN_LIMIT;
    if (v > SHORT_LIMIT) return SHORT_LIMIT;
    return v;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    if ($urandom_range(0, 1) == 0) return GAIN_W'($urandom_range(0, 262143));
    return GAIN_W'($urandom());
  endfunction

  function automatic reg_set_t random_settings();
    reg_set_t s;
    s.setpoint = SETP_W'($urandom_range(0, 8191));
    s.band = BAND_W'($urandom_range(0, 1023));
    s.fan_level = FAN_W'($urandom_range(0, 255));
    s.gain_p = random_gain();
    s.gain_i = random_gain();
    s.gain_d = random_gain();
    s.heater_max = HMAX_W'($urandom_range(0, 255));
    return s;
  endfunction

  task automatic send_tick(input int a1, input int a2, input int th, input int dt);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    air1_temp <= TEMP_W'(a1);
    air2_temp <= TEMP_W'(a2);
    heater_temp <= TEMP_W'(th);
    elapsed_ms <= DT_W'(dt);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic random_tick();
    int r;
    int spread;
    int a1;
    int a2;
    int th;
    int dt;
    int bad_val;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      noise_ticks++;
      send_tick(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()));
    end else begin
      case ($urandom_range(0, 2))
        0: spread = 3000;
        1: spread = 500;
        default: spread = 40;
      endcase
      a1 = clamp_temp(cur_setpoint + int'($urandom_range(0, 2 * spread)) - spread);
      a2 = clamp_temp(a1 + int'($urandom_range(0, 80)) - 40);
      case ($urandom_range(0, 3))
        0, 1: th = int'($urandom_range(0, 10699)) - 3000;
        2: th = int'($urandom_range(7650, 8050));
        default: th = int'($urandom_range(8000, 12000));
      endcase
      case ($urandom_range(0, 9))
        0: dt = 0;
        8, 9: dt = int'($urandom_range(0, 65535));
        default: dt = int'($urandom_range(1, 2000));
      endcase
      if (r >= 85) begin
        if ($urandom_range(0, 1) == 0) bad_val = OPEN_LIMIT - int'($urandom_range(1, 300));
        else bad_val = SHORT_LIMIT + int'($urandom_range(1, 300));
        case ($urandom_range(0, 2))
          0: a1 = bad_val;
          1: a2 = bad_val;
          default: th = bad_val;
        endcase
      end
      send_tick(a1, a2, th, dt);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                           input int width);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= (CFG_W'($urandom()) << width) | data;
    @(posedge clk);
  endtask

  task automatic program_regs(input reg_set_t s);
    write_reg(CFG_SETPOINT, CFG_W'(s.setpoint), SETP_W);
    write_reg(CFG_BAND, CFG_W'(s.band), BAND_W);
    write_reg(CFG_FAN_LEVEL, CFG_W'(s.fan_level), FAN_W);
    write_reg(CFG_GAIN_P, CFG_W'(s.gain_p), GAIN_W);
    write_reg(CFG_GAIN_I, CFG_W'(s.gain_i), GAIN_W);
    write_reg(CFG_GAIN_D, CFG_W'(s.gain_d), GAIN_W);
    write_reg(CFG_HEATER_MAX, CFG_W'(s.heater_max), HMAX_W);
    write_reg(CFG_UNUSED, CFG_W'($urandom()), CFG_W);
    cfg_we <= 1'b0;
    cur_setpoint = s.setpoint;
    settings_applied++;
  endtask

  task automatic wait_idle(input int tail);
    in_valid <= 1'b0;
    while (ticks_checked != sent) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  initial begin : drain_side
    int unsigned stall;
    @(posedge clk);
    forever begin
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_tick(3400, 3400, 5000, 1000);
    send_tick(3000, 3000, 7699, 0);
    send_tick(3000, 3001, 7700, 65535);
    send_tick(3100, 3100, 7999, 1);
    send_tick(3100, 3100, 8000, 500);
    send_tick(3379, 3379, 5000, 100);
    send_tick(3380, 3380, 5000, 100);
    send_tick(3420, 3420, 5000, 100);
    send_tick(3421, 3421, 5000, 100);
    send_tick(-3000, -2999, 5000, 100);
    send_tick(12000, 12000, 12000, 100);
    send_tick(-3001, 3400, 5000, 100);
    send_tick(12001, 3400, 5000, 100);
    send_tick(3400, -3001, 5000, 100);
    send_tick(3400, 12001, 5000, 100);
    send_tick(3400, 3400, -3001, 100);
    send_tick(3400, 3400, 12001, 100);
    send_tick(-32768, 32767, 32767, 0);
    send_tick(3400, -32768, 32767, 7);
    send_tick(32767, 32767, -32768, 65535);
    send_tick(-32768, -32768, 5000, 100);
    send_tick(3000, 3000, -32768, 100);
    send_tick(2000, 2000, 7000, 10);

    for (int p = 0; p < SETTING_RUNS; p++) begin
      wait_idle(4);
      case (p)
        0: program_regs('{13'd0, 10'd1023, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd0});
        1: program_regs('{13'd8191, 10'd0, 8'd34, 24'd0, 24'd0, 24'd0, 8'd1});
        2: program_regs('{13'd3400, 10'd10, 8'd250, 24'd45875, 24'd328, 24'd65536, 8'd100});
        default: program_regs(random_settings());
      endcase
      steady = ($urandom_range(0, 3) == 0);
      repeat (TICKS_PER_SET) random_tick();
    end

    wait_idle(DRAIN_CYCLES);
    $display("Covered %0d control ticks (%0d of raw noise) over reset values and %0d settings,",
             sent, noise_ticks, settings_applied);
    $display("with %0d results checked and %0d mismatches.", ticks_checked, tick_fails);
    if (tick_fails == 0 && ticks_checked == sent)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
